// ===== rtl/pxfc_pkg.sv =====
// Shared types and constants for the predictive XOR float compressor.
package pxfc_pkg;

    // Configuration register port
    localparam int CFG_W     = 11;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_LENGTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_LEN_RESET    = 11'd1024;

    // Block length limits and position counter width
    localparam int BLOCK_MAX = 1024;
    localparam int BPOS_W    = 10;

    // Item commands
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_COMPRESS = 1'b1;

    // Output stream codes
    localparam logic SEL_PREFIX   = 1'b0;
    localparam logic SEL_RESIDUAL = 1'b1;

    // Residual magnitude mask and zero-byte count cap
    localparam logic [31:0] MAG_MASK = 32'h7FFF_FFFF;
    localparam logic [1:0]  ZB_CAP   = 2'd3;

    // Job queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // One classified compress item, handed from front to back
    typedef struct packed {
        logic [2:0]  prefix;
        logic [1:0]  zb;
        logic [31:0] rbits;
        logic        block_end;
    } t_job;

    // One output beat
    typedef struct packed {
        logic        sel;
        logic [31:0] data;
        logic        last;
    } t_word;

    // Result of appending bits to a packer
    typedef struct packed {
        logic        full;
        logic [31:0] word;
        logic [31:0] acc;
        logic [4:0]  fill;
    } t_pack;

    // Both history words of one frame position
    typedef struct packed {
        logic [31:0] older;
        logic [31:0] newer;
    } t_hist;

endpackage

// ===== rtl/pxfc_front.sv =====
// Front end: accepts items, tracks positions, updates history and classifies residuals.
module pxfc_front import pxfc_pkg::*; #(
    parameter int FRAME_MAX = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_cmd,
    input  logic [31:0]      i_value,
    input  logic [CFG_W-1:0] i_frame_length,
    input  logic [CFG_W-1:0] i_block_length,
    output logic             o_push,
    output t_job             o_job,
    input  logic             i_full
);

    localparam int AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
    localparam int PW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    logic [AW-1:0]     r_frame_pos, n_frame_pos;
    logic [BPOS_W-1:0] r_blk_pos, n_blk_pos;
    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_cmd;
    logic [31:0]       r_s1_val;
    logic [AW-1:0]     r_s1_pos;
    logic              r_s1_bend;
    t_hist             r_mem [FRAME_MAX];
    t_hist             r_rd;
    logic              r_byp;
    t_hist             r_byp_data;

    logic [PW-1:0]     flen;
    logic [CFG_W-1:0]  blen;
    logic              frame_end;
    logic              blk_end;
    logic              accept;
    logic              s1_adv;
    t_hist             hist;
    t_hist             wr_data;
    logic [31:0]       pred;
    logic [31:0]       res;
    logic [31:0]       mag;
    logic [1:0]        zb;

    // Effective lengths: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (i_frame_length == '0) begin
            flen = PW'(1);
        end else if (PW'(i_frame_length) > PW'(FRAME_MAX)) begin
            flen = PW'(FRAME_MAX);
        end else begin
            flen = PW'(i_frame_length);
        end
        if (i_block_length == '0) begin
            blen = CFG_W'(1);
        end else if (i_block_length > CFG_W'(BLOCK_MAX)) begin
            blen = CFG_W'(BLOCK_MAX);
        end else begin
            blen = i_block_length;
        end
    end

    // Handshake: stage one holds a compress item while the queue is full.
    assign s1_adv  = r_s1_valid && ((r_s1_cmd == CMD_LOAD) || !i_full);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    // Frame and block position bookkeeping at accept time.
    assign frame_end = (PW'(r_frame_pos) + PW'(1)) >= flen;
    assign blk_end   = frame_end || ((CFG_W'(r_blk_pos) + CFG_W'(1)) >= blen);

    always_comb begin
        n_frame_pos = r_frame_pos;
        n_blk_pos   = r_blk_pos;
        if (accept) begin
            n_frame_pos = frame_end ? '0 : r_frame_pos + AW'(1);
            if (i_cmd == CMD_COMPRESS) begin
                n_blk_pos = blk_end ? '0 : r_blk_pos + BPOS_W'(1);
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pos <= '0;
            r_blk_pos   <= '0;
            r_s1_valid  <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_frame_pos <= n_frame_pos;
            r_blk_pos   <= n_blk_pos;
            r_s1_valid  <= n_s1_valid;
            if (accept) begin
                r_byp <= s1_adv && (r_s1_pos == r_frame_pos);
            end
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= i_cmd;
            r_s1_val   <= i_value;
            r_s1_pos   <= r_frame_pos;
            r_s1_bend  <= blk_end;
            r_byp_data <= wr_data;
        end
    end

    // History memory: read at accept, written back when stage one leaves.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_pos] <= wr_data;
        end
        if (accept) begin
            r_rd <= r_mem[r_frame_pos];
        end
    end

    // A write to the position just read is forwarded past the memory.
    assign hist = r_byp ? r_byp_data : r_rd;

    always_comb begin
        if (r_s1_cmd == CMD_LOAD) begin
            wr_data.older = r_s1_val;
        end else begin
            wr_data.older = hist.newer;
        end
        wr_data.newer = r_s1_val;
    end

    // Prediction is the signed minimum of the two history words.
    assign pred = ($signed(hist.older) <= $signed(hist.newer)) ? hist.older : hist.newer;
    assign res  = r_s1_val ^ pred;
    assign mag  = res & MAG_MASK;

    always_comb begin
        if (mag[30:8] == '0) begin
            zb = ZB_CAP;
        end else if (mag[30:16] == '0) begin
            zb = 2'd2;
        end else if (mag[30:24] == '0) begin
            zb = 2'd1;
        end else begin
            zb = 2'd0;
        end
    end

    assign o_job.prefix    = {res[31], zb};
    assign o_job.zb        = zb;
    assign o_job.rbits     = res & (32'hFFFF_FFFF >> {zb, 3'b000});
    assign o_job.block_end = r_s1_bend;
    assign o_push          = r_s1_valid && (r_s1_cmd == CMD_COMPRESS) && !i_full;

endmodule

// ===== rtl/pxfc_queue.sv =====
// Short job queue between the front end and the packer.
module pxfc_queue import pxfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job             r_slot [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QAW:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rp];

    // Pointer and count update.
    always_comb begin
        n_wp  = i_push ? r_wp + QAW'(1) : r_wp;
        n_rp  = i_pop  ? r_rp + QAW'(1) : r_rp;
        n_cnt = r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    // The count never passes the depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("job queue count beyond depth");

    // The front never writes a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job queue overflow");

endmodule

// ===== rtl/pxfc_back.sv =====
// Back end: packs prefixes and residuals into two word streams and drives the output beats.
module pxfc_back import pxfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_stream_sel,
    output logic [31:0] o_packed_word,
    output logic        o_block_last
);

    logic [31:0] r_pacc, n_pacc;
    logic [4:0]  r_pfill, n_pfill;
    logic [31:0] r_racc, n_racc;
    logic [4:0]  r_rfill, n_rfill;
    logic [3:0]  r_pv, n_pv;
    t_word       r_pw [4];
    logic        r_out_valid, n_out_valid;
    t_word       r_out;

    t_pack       pp;
    t_pack       rp;
    logic [5:0]  nbits;
    logic [3:0]  new_v;
    t_word       new_w [4];
    logic        out_free;
    logic        move;
    logic [1:0]  idx;
    logic [3:0]  rem;
    logic [3:0]  pend_last;

    // Append n bits MSB first to a 32-bit accumulator.
    function automatic t_pack pack_bits(input logic [31:0] acc, input logic [4:0] fill,
                                        input logic [31:0] bits, input logic [5:0] n);
        logic [5:0]  total;
        logic [6:0]  sh;
        logic [63:0] win;
        t_pack       r;
        total = {1'b0, fill} + n;
        sh    = 7'd64 - {1'b0, total};
        win   = {acc, 32'h0} | ({32'h0, bits} << sh);
        if (total >= 6'd32) begin
            r.full = 1'b1;
            r.word = win[63:32];
            r.acc  = win[31:0];
            r.fill = 5'(total - 6'd32);
        end else begin
            r.full = 1'b0;
            r.word = win[63:32];
            r.acc  = win[63:32];
            r.fill = total[4:0];
        end
        return r;
    endfunction

    // Both packers work on the job at the queue head.
    assign nbits = {3'(3'd4 - {1'b0, i_head.zb}), 3'b000};
    assign pp    = pack_bits(r_pacc, r_pfill, {29'h0, i_head.prefix}, 6'd3);
    assign rp    = pack_bits(r_racc, r_rfill, i_head.rbits, nbits);

    // Words of one job in stream order: prefix full, prefix flush, residual full, flush.
    always_comb begin
        new_v[0]      = pp.full;
        new_w[0].sel  = SEL_PREFIX;
        new_w[0].data = pp.word;
        new_w[0].last = i_head.block_end && (pp.fill == '0);
        new_v[1]      = i_head.block_end && (pp.fill != '0);
        new_w[1].sel  = SEL_PREFIX;
        new_w[1].data = pp.acc;
        new_w[1].last = 1'b1;
        new_v[2]      = rp.full;
        new_w[2].sel  = SEL_RESIDUAL;
        new_w[2].data = rp.word;
        new_w[2].last = i_head.block_end && (rp.fill == '0);
        new_v[3]      = i_head.block_end && (rp.fill != '0);
        new_w[3].sel  = SEL_RESIDUAL;
        new_w[3].data = rp.acc;
        new_w[3].last = 1'b1;
    end

    // Pick the first pending word for the output register.
    always_comb begin
        if (r_pv[0]) begin
            idx = 2'd0;
        end else if (r_pv[1]) begin
            idx = 2'd1;
        end else if (r_pv[2]) begin
            idx = 2'd2;
        end else begin
            idx = 2'd3;
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign move     = out_free && (r_pv != '0);
    assign rem      = move ? (r_pv & ~(4'b0001 << idx)) : r_pv;
    assign o_pop    = !i_empty && (rem == '0);

    always_comb begin
        n_pv        = o_pop ? new_v : rem;
        n_out_valid = r_out_valid;
        if (move) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
        n_pacc  = r_pacc;
        n_pfill = r_pfill;
        n_racc  = r_racc;
        n_rfill = r_rfill;
        if (o_pop) begin
            n_pacc  = i_head.block_end ? '0 : pp.acc;
            n_pfill = i_head.block_end ? '0 : pp.fill;
            n_racc  = i_head.block_end ? '0 : rp.acc;
            n_rfill = i_head.block_end ? '0 : rp.fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pacc      <= '0;
            r_pfill     <= '0;
            r_racc      <= '0;
            r_rfill     <= '0;
            r_pv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pacc      <= n_pacc;
            r_pfill     <= n_pfill;
            r_racc      <= n_racc;
            r_rfill     <= n_rfill;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    // Pending words and output register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pw[0] <= new_w[0];
            r_pw[1] <= new_w[1];
            r_pw[2] <= new_w[2];
            r_pw[3] <= new_w[3];
        end
        if (move) begin
            r_out <= r_pw[idx];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_stream_sel  = r_out.sel;
    assign o_packed_word = r_out.data;
    assign o_block_last  = r_out.last;

    always_comb begin
        pend_last[0] = r_pv[0] && r_pw[0].last;
        pend_last[1] = r_pv[1] && r_pw[1].last;
        pend_last[2] = r_pv[2] && r_pw[2].last;
        pend_last[3] = r_pv[3] && r_pw[3].last;
    end

    // A block end leaves both packers empty.
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.block_end |=> (r_pfill == '0) && (r_rfill == '0))
        else $error("packer not empty after block end");

    // A block end marks exactly one word in each stream as last.
    a_two_lasts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.block_end |=> $countones(pend_last) == 2)
        else $error("block end did not mark one last word per stream");

endmodule

// ===== rtl/predictive_xor_float_compressor.sv =====
// Top level of the predictive XOR float compressor.
//
// Input beats carry a command and a 32-bit float word. A load beat writes the
// word into both history slots of the current frame position and yields no
// output. A compress beat yields zero to four output beats, each a 32-bit word
// of the prefix stream or the residual stream, prefix words first.
// Both channels use valid and stall; the block takes one input beat per clock
// while o_stall is low, and a four-entry job queue keeps beats coming while
// output words wait. A compress beat passes stage one, the job queue, the
// pending words and the output register. The sustained rate is one beat per
// cycle when not stalled, set by the history read-modify-write; the output
// carries one word per cycle, so a compress beat yielding several words holds
// the packer while they drain. Receiver stalls fill the job queue and then
// raise the input stall. Reset clears positions, packers, queue and output, not
// the history: the user must load every position before it is compressed, and
// write the length registers (reset 1024) only while idle; neither is enforced.
module predictive_xor_float_compressor import pxfc_pkg::*; #(
    parameter int FRAME_MAX = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [31:0]          i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_stream_sel,
    output logic [31:0]          o_packed_word,
    output logic                 o_block_last
);

    logic [CFG_W-1:0] r_frame_length;
    logic [CFG_W-1:0] r_block_length;
    logic             push;
    t_job             push_job;
    logic             q_full;
    logic             q_empty;
    t_job             q_head;
    logic             pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= CFG_LEN_RESET;
            r_block_length <= CFG_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_LENGTH: r_frame_length <= i_cfg_data;
                REG_BLOCK_LENGTH: r_block_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pxfc_front #(
        .FRAME_MAX(FRAME_MAX)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_frame_length (r_frame_length),
        .i_block_length (r_block_length),
        .o_push         (push),
        .o_job          (push_job),
        .i_full         (q_full)
    );

    pxfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    pxfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (q_head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_stream_sel  (o_stream_sel),
        .o_packed_word (o_packed_word),
        .o_block_last  (o_block_last)
    );

endmodule
